@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is ignored while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Concurrent assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

@@ hw/rtl/rwlm_pkg.sv @@
// Types, constants and helpers of the reader/writer lock manager.
package rwlm_pkg;

    // Field widths
    localparam int TYPE_W = 2;
    localparam int ID_W   = 4;
    localparam int AMT_W  = 8;
    localparam int RSP_W  = 3;
    localparam int CNT_W  = 5;
    localparam int TOT_W  = 16;

    // Stream data widths (fields packed from bit 0, padded to bytes)
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 8;

    // Wait queues
    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request queue between front and back
    localparam int RF_DEPTH = 4;
    localparam int RF_PTR_W = $clog2(RF_DEPTH);
    localparam int RF_CNT_W = $clog2(RF_DEPTH + 1);

    typedef enum logic [TYPE_W-1:0] {
        REQ_RD_OPEN  = 2'd0,
        REQ_RD_CLOSE = 2'd1,
        REQ_WR_OPEN  = 2'd2,
        REQ_WR_CLOSE = 2'd3
    } t_req_kind;

    typedef enum logic [RSP_W-1:0] {
        RSP_EMPTY   = 3'd0,
        RSP_RD_YES  = 3'd1,
        RSP_RD_WAIT = 3'd2,
        RSP_WR_YES  = 3'd3,
        RSP_WR_WAIT = 3'd4,
        RSP_FULL    = 3'd5
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_GRANT_WR = 2'd1,
        ST_DRAIN_RD = 2'd2
    } t_bk_state;

    typedef struct packed {
        t_req_kind             kind;
        logic [ID_W-1:0]       id;
        logic [AMT_W-1:0]      amount;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0]       id;
        t_rsp                  rsp;
        logic                  last;
    } t_result;

    // Wait queue pointer advance with wrap at any depth
    function automatic logic [QPTR_W-1:0] qptr_next(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        r = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

endpackage

@@ hw/rtl/rwlm_front.sv @@
// Front part: accepts request transactions, decodes them, queues them for the back part.
module rwlm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [rwlm_pkg::S_DATA_W-1:0] i_s_tdata,
    input  logic [rwlm_pkg::TYPE_W-1:0]   i_s_tuser,
    output logic                          o_req_valid,
    output rwlm_pkg::t_req                o_req,
    input  logic                          i_req_pop
);
    import rwlm_pkg::*;

    t_req                r_mem [RF_DEPTH];
    logic [RF_PTR_W-1:0] r_wr_ptr;
    logic [RF_PTR_W-1:0] r_rd_ptr;
    logic [RF_CNT_W-1:0] r_count;
    logic                push;
    logic                pop;
    t_req                dec_req;

    // Decode the incoming transaction
    always_comb begin
        dec_req.kind   = t_req_kind'(i_s_tuser);
        dec_req.id     = i_s_tdata[ID_W-1:0];
        dec_req.amount = i_s_tdata[ID_W +: AMT_W];
    end

    assign o_s_tready  = (r_count != RF_CNT_W'(RF_DEPTH));
    assign push        = i_s_tvalid && o_s_tready;
    assign o_req_valid = (r_count != '0);
    assign pop         = i_req_pop && o_req_valid;
    assign o_req       = r_mem[r_rd_ptr];

    // Request storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= dec_req;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/rwlm_back.sv @@
// Back part: lock state, wait queues, grant sequencer and output register.
module rwlm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  rwlm_pkg::t_req    i_req,
    output logic              o_req_pop,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output rwlm_pkg::t_result o_result
);
    import rwlm_pkg::*;

    t_bk_state         r_state, n_state;
    logic [CNT_W-1:0]  r_readers, n_readers;
    logic [CNT_W-1:0]  r_writers, n_writers;
    logic [TOT_W-1:0]  r_total, n_total;

    // Wait queues of client ids
    logic [ID_W-1:0]   r_wq [QUEUE_DEPTH];
    logic [ID_W-1:0]   r_rq [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wq_head, r_wq_tail;
    logic [QPTR_W-1:0] r_rq_head, r_rq_tail;
    logic [QCNT_W-1:0] r_wq_cnt, r_rq_cnt;

    logic              r_out_valid;
    t_result           r_out;

    logic              out_free;
    logic              emit;
    t_result           res;
    logic              wq_push, wq_pop, rq_push, rq_pop;
    logic [CNT_W-1:0]  rd_inc, rd_dec, wr_inc, wr_dec;
    logic [TOT_W:0]    tot_sum;

    assign out_free = !r_out_valid || i_m_tready;

    // Saturating count steps
    always_comb begin
        rd_inc  = (r_readers == '1) ? r_readers : r_readers + 1'b1;
        rd_dec  = (r_readers == '0) ? r_readers : r_readers - 1'b1;
        wr_inc  = (r_writers == '1) ? r_writers : r_writers + 1'b1;
        wr_dec  = (r_writers == '0) ? r_writers : r_writers - 1'b1;
        tot_sum = {1'b0, r_total} + (TOT_W + 1)'(i_req.amount);
    end

    // Sequencer: first answer from the request, then queued grants one per cycle while the output register is free
    always_comb begin
        n_state   = r_state;
        n_readers = r_readers;
        n_writers = r_writers;
        n_total   = r_total;
        o_req_pop = 1'b0;
        emit      = 1'b0;
        wq_push   = 1'b0;
        wq_pop    = 1'b0;
        rq_push   = 1'b0;
        rq_pop    = 1'b0;
        res.id    = i_req.id;
        res.rsp   = RSP_EMPTY;
        res.last  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid && out_free) begin
                    o_req_pop = 1'b1;
                    emit      = 1'b1;
                    case (i_req.kind)
                        REQ_RD_OPEN: begin
                            if (r_total == '0) begin
                                res.rsp = RSP_EMPTY;
                            end else if (r_writers == '0) begin
                                n_readers = rd_inc;
                                res.rsp   = RSP_RD_YES;
                            end else if (r_rq_cnt != QCNT_W'(QUEUE_DEPTH)) begin
                                rq_push = 1'b1;
                                res.rsp = RSP_RD_WAIT;
                            end else begin
                                res.rsp = RSP_FULL;
                            end
                        end
                        REQ_RD_CLOSE: begin
                            n_readers = rd_dec;
                            res.rsp   = RSP_RD_YES;
                            if (r_wq_cnt != '0 && rd_dec == '0) begin
                                res.last = 1'b0;
                                n_state  = ST_GRANT_WR;
                            end
                        end
                        REQ_WR_OPEN: begin
                            if (r_readers == '0 && r_writers == '0) begin
                                n_writers = wr_inc;
                                res.rsp   = RSP_WR_YES;
                            end else if (r_wq_cnt != QCNT_W'(QUEUE_DEPTH)) begin
                                wq_push = 1'b1;
                                res.rsp = RSP_WR_WAIT;
                            end else begin
                                res.rsp = RSP_FULL;
                            end
                        end
                        REQ_WR_CLOSE: begin
                            n_writers = wr_dec;
                            n_total   = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
                            res.rsp   = RSP_WR_YES;
                            if (r_wq_cnt != '0 && r_readers == '0) begin
                                res.last = 1'b0;
                                n_state  = ST_GRANT_WR;
                            end else if (r_rq_cnt != '0) begin
                                res.last = 1'b0;
                                n_state  = ST_DRAIN_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_GRANT_WR: begin
                res.id  = r_wq[r_wq_head];
                res.rsp = RSP_WR_YES;
                if (out_free) begin
                    emit      = 1'b1;
                    wq_pop    = 1'b1;
                    n_writers = wr_inc;
                    n_state   = ST_IDLE;
                end
            end
            ST_DRAIN_RD: begin
                res.id   = r_rq[r_rq_head];
                res.rsp  = RSP_RD_YES;
                res.last = (r_rq_cnt == QCNT_W'(1));
                if (out_free) begin
                    emit      = 1'b1;
                    rq_pop    = 1'b1;
                    n_readers = rd_inc;
                    if (res.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_readers <= '0;
            r_writers <= '0;
            r_total   <= '0;
        end else begin
            r_state   <= n_state;
            r_readers <= n_readers;
            r_writers <= n_writers;
            r_total   <= n_total;
        end
    end

    // Wait queue storage
    always_ff @(posedge i_clk) begin
        if (wq_push) begin
            r_wq[r_wq_tail] <= i_req.id;
        end
        if (rq_push) begin
            r_rq[r_rq_tail] <= i_req.id;
        end
    end

    // Wait queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wq_head <= '0;
            r_wq_tail <= '0;
            r_wq_cnt  <= '0;
            r_rq_head <= '0;
            r_rq_tail <= '0;
            r_rq_cnt  <= '0;
        end else begin
            if (wq_push) begin
                r_wq_tail <= qptr_next(r_wq_tail);
                r_wq_cnt  <= r_wq_cnt + 1'b1;
            end else if (wq_pop) begin
                r_wq_head <= qptr_next(r_wq_head);
                r_wq_cnt  <= r_wq_cnt - 1'b1;
            end
            if (rq_push) begin
                r_rq_tail <= qptr_next(r_rq_tail);
                r_rq_cnt  <= r_rq_cnt + 1'b1;
            end else if (rq_pop) begin
                r_rq_head <= qptr_next(r_rq_head);
                r_rq_cnt  <= r_rq_cnt - 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_result   = r_out;

endmodule

@@ hw/rtl/reader_writer_lock_manager_core.sv @@
// Reader/writer lock manager: request stream in, response stream out.
//
// Slave stream carries one lock request per transaction: the request kind
// on tuser, the requester id and, for a writer close, the amount written on
// tdata. The master stream returns one or more responses per request; tlast
// marks the final response of each request.
// The first response of a request passes through the request queue and the
// response register before it shows on the master side. A close that
// releases queued clients is followed by one grant response per released
// client, up to QUEUE_DEPTH grants when all queued readers are released;
// the grant sequencer in the back part takes no new request while it runs,
// and a four-entry request queue in front keeps accepting meanwhile.
// Reset (synchronous, active low) empties both wait queues and the request
// queue and clears all counts. When the receiver holds tready low the
// response register holds its transaction, the sequencer stops, and the
// request queue fills until tready on the slave side drops.
module reader_writer_lock_manager_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [3:0] requester_id, [11:4] write_amount, [15:12] zero
    input  logic [rwlm_pkg::S_DATA_W-1:0] i_s_tdata,
    // [1:0] req_type
    input  logic [rwlm_pkg::TYPE_W-1:0]   i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [3:0] dest_id, [6:4] response, [7] zero
    output logic [rwlm_pkg::M_DATA_W-1:0] o_m_tdata,
    output logic                          o_m_tlast
);
    import rwlm_pkg::*;

    logic    req_valid;
    t_req    req;
    logic    req_pop;
    t_result result;

    rwlm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_pop   (req_pop)
    );

    rwlm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_pop   (req_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_result    (result)
    );

    // Pack the response transaction
    assign o_m_tdata = {{(M_DATA_W - ID_W - RSP_W){1'b0}}, result.rsp, result.id};
    assign o_m_tlast = result.last;

endmodule

@@ hw/rtl/rwlm_checker.sv @@
// Port-level checker for the lock manager and its bind.
`include "assert_macros.svh"

module rwlm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [rwlm_pkg::M_DATA_W-1:0] o_m_tdata,
    input logic                          o_m_tlast
);
    import rwlm_pkg::*;

    logic [RSP_W-1:0]  rsp;
    logic              single_rsp;
    logic              is_grant;
    logic              out_stall;
    logic              run_cont;
    logic [M_DATA_W:0] out_word;

    assign rsp        = o_m_tdata[ID_W +: RSP_W];
    assign single_rsp = (rsp == RSP_EMPTY) || (rsp == RSP_RD_WAIT) ||
                        (rsp == RSP_WR_WAIT) || (rsp == RSP_FULL);
    assign is_grant   = (rsp == RSP_RD_YES) || (rsp == RSP_WR_YES);
    assign out_stall  = o_m_tvalid && !i_m_tready;
    assign run_cont   = o_m_tvalid && i_m_tready && !o_m_tlast;
    assign out_word   = {o_m_tlast, o_m_tdata};

    // Reset leaves the request side open and the response side empty
    `ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> o_s_tready && !o_m_tvalid)

    // A stalled response transaction holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, out_stall |=> o_m_tvalid && $stable(out_word))

    // Refusals, waits and queue-full answers never start a grant run
    `ASSERT_CLK(a_single_last, i_clk, i_rst_n, o_m_tvalid && single_rsp |-> o_m_tlast)

    // A response that is not last is followed by a reader or writer grant
    `ASSERT_CLK(a_run_grant, i_clk, i_rst_n, run_cont |=> o_m_tvalid && is_grant)

endmodule

bind reader_writer_lock_manager_core rwlm_checker u_rwlm_checker (.*);

@@ verif/tb_reader_writer_lock_manager_core.sv @@
// Self-checking testbench for the reader/writer lock manager core.
module tb_reader_writer_lock_manager_core;
    import rwlm_pkg::*;

    localparam int CNT_CAP   = (1 << CNT_W) - 1;
    localparam int TOTAL_CAP = (1 << TOT_W) - 1;

    // Lock state predictor plus the queue of responses it still owes
    class rw_lock_scoreboard;
        logic [CNT_W-1:0] n_readers;
        logic [CNT_W-1:0] n_writers;
        logic [TOT_W-1:0] written_total;
        logic [ID_W-1:0]  writer_fifo[$];
        logic [ID_W-1:0]  reader_fifo[$];
        t_result          owed[$];
        int               errors;

        function new();
            n_readers     = '0;
            n_writers     = '0;
            written_total = '0;
            errors        = 0;
        endfunction

        function t_result answer(logic [ID_W-1:0] dest, t_rsp code);
            t_result r;
            r.id   = dest;
            r.rsp  = code;
            r.last = 1'b0;
            return r;
        endfunction

        function logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] v);
            return (v == CNT_W'(CNT_CAP)) ? v : v + 1'b1;
        endfunction

        function logic [CNT_W-1:0] count_down(logic [CNT_W-1:0] v);
            return (v == '0) ? v : v - 1'b1;
        endfunction

        // Work out every response one accepted request transaction causes
        function void note_request(t_req_kind kind, logic [ID_W-1:0] rid,
                                   logic [AMT_W-1:0] amount);
            t_result batch[$];
            int      sum;
            case (kind)
                REQ_RD_OPEN: begin
                    if (written_total == '0) begin
                        batch.push_back(answer(rid, RSP_EMPTY));
                    end else if (n_writers == '0) begin
                        n_readers = count_up(n_readers);
                        batch.push_back(answer(rid, RSP_RD_YES));
                    end else if (reader_fifo.size() < QUEUE_DEPTH) begin
                        reader_fifo.push_back(rid);
                        batch.push_back(answer(rid, RSP_RD_WAIT));
                    end else begin
                        batch.push_back(answer(rid, RSP_FULL));
                    end
                end
                REQ_RD_CLOSE: begin
                    n_readers = count_down(n_readers);
                    batch.push_back(answer(rid, RSP_RD_YES));
                    if (writer_fifo.size() > 0 && n_readers == '0) begin
                        n_writers = count_up(n_writers);
                        batch.push_back(answer(writer_fifo.pop_front(), RSP_WR_YES));
                    end
                end
                REQ_WR_OPEN: begin
                    if (n_readers == '0 && n_writers == '0) begin
                        n_writers = count_up(n_writers);
                        batch.push_back(answer(rid, RSP_WR_YES));
                    end else if (writer_fifo.size() < QUEUE_DEPTH) begin
                        writer_fifo.push_back(rid);
                        batch.push_back(answer(rid, RSP_WR_WAIT));
                    end else begin
                        batch.push_back(answer(rid, RSP_FULL));
                    end
                end
                default: begin
                    n_writers = count_down(n_writers);
                    sum = int'(written_total) + int'(amount);
                    written_total = (sum > TOTAL_CAP) ? TOT_W'(TOTAL_CAP) : TOT_W'(sum);
                    batch.push_back(answer(rid, RSP_WR_YES));
                    if (writer_fifo.size() > 0 && n_readers == '0) begin
                        n_writers = count_up(n_writers);
                        batch.push_back(answer(writer_fifo.pop_front(), RSP_WR_YES));
                    end else begin
                        // release every queued reader, oldest first
                        while (reader_fifo.size() > 0) begin
                            n_readers = count_up(n_readers);
                            batch.push_back(answer(reader_fifo.pop_front(), RSP_RD_YES));
                        end
                    end
                end
            endcase
            batch[batch.size()-1].last = 1'b1;
            foreach (batch[i]) owed.push_back(batch[i]);
        endfunction

        // Compare one response transaction with the oldest owed response
        function void check_result(logic [M_DATA_W-1:0] data, logic last);
            t_result want;
            if (owed.size() == 0) begin
                $display("%0t: unexpected response dest %0d rsp %0d last %0d",
                         $time, data[3:0], data[6:4], last);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (data[3:0] !== want.id || data[6:4] !== want.rsp || last !== want.last) begin
                $display("%0t: expected dest %0d rsp %0d last %0d,",
                         $time, want.id, want.rsp, want.last,
                         " got dest %0d rsp %0d last %0d",
                         data[3:0], data[6:4], last);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata;
    logic [TYPE_W-1:0]   i_s_tuser;
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [M_DATA_W-1:0] o_m_tdata;
    logic                o_m_tlast;

    rw_lock_scoreboard store;
    int                idle_pct;
    int                stall_pct;
    int                n_sent;

    reader_writer_lock_manager_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Response side backpressure
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Response monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            store.check_result(o_m_tdata, o_m_tlast);
    end

    initial begin
        #5_000_000;
        $display("[reader_writer_lock_manager_core] ERROR");
        $finish;
    end

    // Drive one request; called at a falling edge, returns at a falling edge
    task automatic send_req(t_req_kind kind, logic [ID_W-1:0] rid, logic [AMT_W-1:0] amount);
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {4'b0000, amount, rid};
        do @(posedge i_clk); while (!o_s_tready);
        store.note_request(kind, rid, amount);
        n_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [AMT_W-1:0] pick_amount();
        return ($urandom_range(3) == 0) ? 8'hFF : AMT_W'($urandom_range(255));
    endfunction

    // Random traffic made of lock sessions plus some noise, or runs of large writes in storm mode
    task automatic run_traffic(int n_items, int idle, int stall, bit storm);
        int               stop;
        int               roll;
        int               k;
        int               w;
        logic [ID_W-1:0]  wid;
        stop      = n_sent + n_items;
        idle_pct  = idle;
        stall_pct = stall;
        while (n_sent < stop) begin
            roll = $urandom_range(99);
            if (storm) begin
                // run of large writes to push the total up
                k = $urandom_range(1, 8);
                repeat (k) send_req(REQ_WR_CLOSE, ID_W'($urandom_range(15)), 8'hFF);
                send_req(t_req_kind'($urandom_range(3)), ID_W'($urandom_range(15)),
                         pick_amount());
            end else if (roll < 35) begin
                // writer holds the lock while readers pile up behind it
                wid = ID_W'($urandom_range(15));
                send_req(REQ_WR_OPEN, wid, AMT_W'($urandom_range(255)));
                k = $urandom_range(0, 20);
                repeat (k) send_req(REQ_RD_OPEN, ID_W'($urandom_range(15)),
                                    AMT_W'($urandom_range(255)));
                send_req(REQ_WR_CLOSE, wid, pick_amount());
            end else if (roll < 65) begin
                // readers share the lock, writers queue, readers leave
                k = $urandom_range(1, 35);
                w = $urandom_range(0, 18);
                repeat (k) send_req(REQ_RD_OPEN, ID_W'($urandom_range(15)),
                                    AMT_W'($urandom_range(255)));
                repeat (w) send_req(REQ_WR_OPEN, ID_W'($urandom_range(15)),
                                    AMT_W'($urandom_range(255)));
                repeat ($urandom_range(0, k + 2))
                    send_req(REQ_RD_CLOSE, ID_W'($urandom_range(15)),
                             AMT_W'($urandom_range(255)));
                repeat ($urandom_range(0, w + 2))
                    send_req(REQ_WR_CLOSE, ID_W'($urandom_range(15)), pick_amount());
            end else begin
                repeat ($urandom_range(1, 6))
                    send_req(t_req_kind'($urandom_range(3)), ID_W'($urandom_range(15)),
                             pick_amount());
            end
        end
    endtask

    initial begin
        store      = new();
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        idle_pct   = 0;
        stall_pct  = 0;
        n_sent     = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty lock, closes at zero, queues, grants and drains
        send_req(REQ_RD_OPEN,  4'd0,  8'h00);
        send_req(REQ_RD_CLOSE, 4'd1,  8'hFF);
        send_req(REQ_WR_CLOSE, 4'd2,  8'h00);
        send_req(REQ_RD_OPEN,  4'd3,  8'h00);
        send_req(REQ_WR_OPEN,  4'd15, 8'h00);
        send_req(REQ_WR_CLOSE, 4'd15, 8'hFF);
        send_req(REQ_WR_OPEN,  4'd14, 8'h00);
        send_req(REQ_RD_OPEN,  4'd5,  8'h00);
        send_req(REQ_RD_OPEN,  4'd6,  8'h00);
        send_req(REQ_WR_OPEN,  4'd4,  8'h00);
        send_req(REQ_WR_CLOSE, 4'd14, 8'h01);
        send_req(REQ_WR_CLOSE, 4'd4,  8'h80);
        send_req(REQ_WR_OPEN,  4'd7,  8'h00);
        send_req(REQ_RD_CLOSE, 4'd5,  8'h00);
        send_req(REQ_RD_CLOSE, 4'd6,  8'h00);
        send_req(REQ_WR_OPEN,  4'd8,  8'h00);
        // reader close with no readers grants a second writer
        send_req(REQ_RD_CLOSE, 4'd10, 8'h00);
        send_req(REQ_WR_OPEN,  4'd11, 8'h00);
        // writer close grants the next writer while another still holds it
        send_req(REQ_WR_CLOSE, 4'd7,  8'hAA);
        send_req(REQ_WR_CLOSE, 4'd8,  8'h55);
        send_req(REQ_WR_CLOSE, 4'd11, 8'h0F);
        send_req(REQ_RD_OPEN,  4'd12, 8'h00);
        send_req(REQ_RD_CLOSE, 4'd12, 8'h00);

        // Random phases: free running, sparse sender, slow receiver, both, a write storm, then both again
        run_traffic(65, 0, 0, 1'b0);
        run_traffic(65, 71, 0, 1'b0);
        run_traffic(65, 0, 71, 1'b0);
        run_traffic(65, 21, 21, 1'b0);
        run_traffic(40, 0, 0, 1'b1);
        run_traffic(20, 21, 21, 1'b0);

        i_s_tvalid <= 1'b0;
        while (store.owed.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (store.owed.size() != 0)
            $display("%0t: %0d responses never arrived", $time, store.owed.size());
        if (store.errors == 0 && store.owed.size() == 0) begin
            $display("[reader_writer_lock_manager_core] OK");
        end else begin
            $display("[reader_writer_lock_manager_core] ERROR");
        end
        $finish;
    end

endmodule
